### hdl/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the sphere pair collision test
// Field widths, pipeline stage records and register map of the block.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Field widths of the transaction payloads.
  localparam int POS_W  = 24;
  localparam int RAD_W  = 16;
  localparam int MASK_W = 32;
  localparam int HALF_W = 16;
  localparam int FLAG_W = 2;
  localparam int NRM_W  = 16;

  // Internal arithmetic widths.
  localparam int D_W    = POS_W + 1;      // axis difference
  localparam int RSUM_W = RAD_W + 1;      // radius sum
  localparam int SQ_W   = 2 * RSUM_W;     // squared axis distance
  localparam int D2_W   = SQ_W + 2;       // squared distance
  localparam int TOL_W  = 10;
  localparam int LIM_W  = SQ_W + TOL_W;   // squared radius sum times tolerance
  localparam int TOL_FRAC = 8;
  localparam int ROOT_W = 32;             // floor(sqrt(dist2 * 2^28))
  localparam int REM_W  = ROOT_W + 2;
  localparam int NRM_SHIFT = 28;
  localparam int SQRT_ZERO_PAIRS = NRM_SHIFT / 2;
  localparam int NUM_W  = RSUM_W + NRM_SHIFT + 1;
  localparam int Q_W    = 16;
  localparam int DIV_W  = ROOT_W + Q_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 10'd269;
  localparam logic [Q_W-1:0]   NRM_MAX   = 16'd16384;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_TOLERANCE = 1'b0;  // word index of tolerance_scale

  // One candidate pair as presented on the input channel.
  typedef struct packed {
    logic signed [POS_W-1:0] one_x;
    logic signed [POS_W-1:0] one_y;
    logic signed [POS_W-1:0] one_z;
    logic signed [POS_W-1:0] two_x;
    logic signed [POS_W-1:0] two_y;
    logic signed [POS_W-1:0] two_z;
    logic [RAD_W-1:0]        one_radius;
    logic [RAD_W-1:0]        two_radius;
    logic [MASK_W-1:0]       one_masks;
    logic [MASK_W-1:0]       two_masks;
    logic [FLAG_W-1:0]       skip_flags;
  } spc_item_t;

  // Result of the overlap test, handed to the square root pipeline.
  typedef struct packed {
    logic                        hit;
    logic [D2_W-1:0]             dist2;
    logic [2:0][RSUM_W-1:0]      mag;
    logic [2:0]                  pos;   // component of two - one is positive
  } spc_geom_t;

  // One square root stage.
  typedef struct packed {
    logic                        hit;
    logic [D2_W-1:0]             dist2;
    logic [ROOT_W-1:0]           root;
    logic [REM_W-1:0]            rem;
    logic [2:0][RSUM_W-1:0]      mag;
    logic [2:0]                  pos;
  } spc_sqrt_t;

  // One divider stage, three lanes sharing the divisor.
  typedef struct packed {
    logic                        hit;
    logic                        zero;
    logic [ROOT_W-1:0]           root;
    logic [2:0][NUM_W-1:0]       rem;
    logic [2:0][Q_W-1:0]         quo;
    logic [2:0]                  pos;
  } spc_div_t;

endpackage

### hdl/spc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_if: channel interfaces of the sphere pair collision test
// Valid/ready channels for candidate pairs and for collision results.
// ----------------------------------------------------------------------------
interface spc_in_if import spc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] one_x;
  logic signed [POS_W-1:0] one_y;
  logic signed [POS_W-1:0] one_z;
  logic signed [POS_W-1:0] two_x;
  logic signed [POS_W-1:0] two_y;
  logic signed [POS_W-1:0] two_z;
  logic [RAD_W-1:0]        one_radius;
  logic [RAD_W-1:0]        two_radius;
  logic [MASK_W-1:0]       one_masks;
  logic [MASK_W-1:0]       two_masks;
  logic [FLAG_W-1:0]       skip_flags;

  modport source (output valid, one_x, one_y, one_z, two_x, two_y, two_z,
                  one_radius, two_radius, one_masks, two_masks, skip_flags,
                  input ready);
  modport sink (input valid, one_x, one_y, one_z, two_x, two_y, two_z,
                one_radius, two_radius, one_masks, two_masks, skip_flags,
                output ready);
endinterface

interface spc_out_if import spc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;

  modport source (output valid, hit, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, hit, normal_x, normal_y, normal_z, output ready);
endinterface

### hdl/spc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_front: filter and overlap test
// Five register stages: differences, magnitudes, squares, sums, compare.
// ----------------------------------------------------------------------------
module spc_front import spc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  spc_item_t        item,
  input  logic [TOL_W-1:0] tol,
  output logic             geom_valid,
  output spc_geom_t        geom
);

  logic [4:0] vld_r;

  logic                    ok1_r, ok1_nxt;
  logic [RSUM_W-1:0]       rsum1_r, rsum1_nxt;
  logic signed [D_W-1:0]   d1_r [3];
  logic signed [D_W-1:0]   d1_nxt [3];

  logic                    ok2_r, ok2_nxt;
  logic [RSUM_W-1:0]       rsum2_r;
  logic [2:0][RSUM_W-1:0]  mag2_r, mag2_nxt;
  logic [2:0]              pos2_r, pos2_nxt;

  logic                    ok3_r;
  logic [2:0][SQ_W-1:0]    sq3_r, sq3_nxt;
  logic [SQ_W-1:0]         rsq3_r, rsq3_nxt;
  logic [2:0][RSUM_W-1:0]  mag3_r;
  logic [2:0]              pos3_r;

  logic                    ok4_r;
  logic [D2_W-1:0]         dist4_r, dist4_nxt;
  logic [LIM_W-1:0]        lim4_r, lim4_nxt;
  logic [2:0][RSUM_W-1:0]  mag4_r;
  logic [2:0]              pos4_r;

  spc_geom_t               geom5_r, geom5_nxt;

  // Stage 1: mask and flag filter, radius sum, signed axis differences.
  always_comb begin
    ok1_nxt = (|(item.one_masks[MASK_W-1:HALF_W] & item.two_masks[HALF_W-1:0])) &&
              (|(item.two_masks[MASK_W-1:HALF_W] & item.one_masks[HALF_W-1:0])) &&
              (item.skip_flags == '0);
    rsum1_nxt = {1'b0, item.one_radius} + {1'b0, item.two_radius};
    d1_nxt[0] = D_W'(item.one_x) - D_W'(item.two_x);
    d1_nxt[1] = D_W'(item.one_y) - D_W'(item.two_y);
    d1_nxt[2] = D_W'(item.one_z) - D_W'(item.two_z);
  end

  // Stage 2: magnitudes and the per-axis bound.
  always_comb begin
    logic [D_W-1:0] m;
    ok2_nxt = ok1_r;
    for (int i = 0; i < 3; i++) begin
      m = d1_r[i][D_W-1] ? D_W'(-d1_r[i]) : D_W'(d1_r[i]);
      if (m > D_W'(rsum1_r)) begin
        ok2_nxt = 1'b0;
      end
      mag2_nxt[i] = m[RSUM_W-1:0];
      pos2_nxt[i] = d1_r[i][D_W-1];
    end
  end

  // Stage 3: squares of the axis distances and of the radius sum.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq3_nxt[i] = mag2_r[i] * mag2_r[i];
    end
    rsq3_nxt = rsum2_r * rsum2_r;
  end

  // Stage 4: squared distance and the tolerance limit.
  always_comb begin
    dist4_nxt = D2_W'(sq3_r[0]) + D2_W'(sq3_r[1]) + D2_W'(sq3_r[2]);
    lim4_nxt  = LIM_W'(rsq3_r) * LIM_W'(tol);
  end

  // Stage 5: overlap compare.
  always_comb begin
    geom5_nxt.hit   = ok4_r && ({dist4_r, {TOL_FRAC{1'b0}}} <= lim4_r);
    geom5_nxt.dist2 = dist4_r;
    geom5_nxt.mag   = mag4_r;
    geom5_nxt.pos   = pos4_r;
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_r   <= ok1_nxt;
      rsum1_r <= rsum1_nxt;
      d1_r    <= d1_nxt;
      ok2_r   <= ok2_nxt;
      rsum2_r <= rsum1_r;
      mag2_r  <= mag2_nxt;
      pos2_r  <= pos2_nxt;
      ok3_r   <= ok2_r;
      sq3_r   <= sq3_nxt;
      rsq3_r  <= rsq3_nxt;
      mag3_r  <= mag2_r;
      pos3_r  <= pos2_r;
      ok4_r   <= ok3_r;
      dist4_r <= dist4_nxt;
      lim4_r  <= lim4_nxt;
      mag4_r  <= mag3_r;
      pos4_r  <= pos3_r;
      geom5_r <= geom5_nxt;
    end
  end

  assign geom_valid = vld_r[4];
  assign geom       = geom5_r;

endmodule

### hdl/spc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_sqrt: pipelined integer square root
// One result bit per stage of floor(sqrt(dist2 * 2^28)), 32 stages.
// ----------------------------------------------------------------------------
module spc_sqrt import spc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      geom_valid,
  input  spc_geom_t geom,
  output logic      root_valid,
  output spc_sqrt_t root_st
);

  spc_sqrt_t init;
  spc_sqrt_t st_r [ROOT_W];
  logic      vld_r [ROOT_W];

  // Entry record: empty root and remainder.
  always_comb begin
    init.hit   = geom.hit;
    init.dist2 = geom.dist2;
    init.root  = '0;
    init.rem   = '0;
    init.mag   = geom.mag;
    init.pos   = geom.pos;
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    spc_sqrt_t        src;
    spc_sqrt_t        nxt;
    logic             src_v;
    logic [1:0]       pair;
    logic [REM_W-1:0] rem_s;
    logic [REM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign src   = init;
      assign src_v = geom_valid;
    end else begin : g_next
      assign src   = st_r[j-1];
      assign src_v = vld_r[j-1];
    end

    // The low radicand pairs come from the 2^28 scale and are zero.
    if (K >= SQRT_ZERO_PAIRS) begin : g_pair
      assign pair = src.dist2[2*K-2*SQRT_ZERO_PAIRS +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    // Trial subtraction for one root bit.
    always_comb begin
      rem_s = {src.rem[REM_W-3:0], pair};
      trial = {src.root, 2'b01};
      nxt   = src;
      if (rem_s >= trial) begin
        nxt.rem  = rem_s - trial;
        nxt.root = {src.root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_s;
        nxt.root = {src.root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= nxt;
      end
    end
  end

  assign root_valid = vld_r[ROOT_W-1];
  assign root_st    = st_r[ROOT_W-1];

endmodule

### hdl/spc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_div: pipelined normal divider
// Three lanes of round((|v| << 28) / S), one quotient bit per stage.
// ----------------------------------------------------------------------------
module spc_div import spc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      root_valid,
  input  spc_sqrt_t root_st,
  output logic      quo_valid,
  output spc_div_t  quo_st
);

  localparam int NST = Q_W + 1;

  spc_div_t setup_nxt;
  spc_div_t st_r  [NST];
  logic     vld_r [NST];

  // Setup stage: rounded numerators, zero-length case.
  always_comb begin
    setup_nxt.hit  = root_st.hit;
    setup_nxt.zero = (root_st.root == '0);
    setup_nxt.root = root_st.root;
    setup_nxt.pos  = root_st.pos;
    setup_nxt.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      setup_nxt.rem[i] = NUM_W'({root_st.mag[i], {NRM_SHIFT{1'b0}}}) +
                         NUM_W'(root_st.root[ROOT_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= setup_nxt;
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar j = 1; j < NST; j++) begin : g_stage
    localparam int B = Q_W - j;
    spc_div_t         nxt;
    logic [DIV_W-1:0] dsr;

    always_comb begin
      dsr = DIV_W'(st_r[j-1].root) << B;
      nxt = st_r[j-1];
      for (int i = 0; i < 3; i++) begin
        if (DIV_W'(st_r[j-1].rem[i]) >= dsr) begin
          nxt.rem[i]    = st_r[j-1].rem[i] - NUM_W'(dsr);
          nxt.quo[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (adv) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= nxt;
      end
    end
  end

  assign quo_valid = vld_r[NST-1];
  assign quo_st    = st_r[NST-1];

endmodule

### hdl/sphere_pair_collision_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_collision_test: streaming sphere pair collision test
// Filters a candidate pair, tests sphere overlap and returns the unit normal.
//
//   Channel   Direction  Handshake        Contents
//   in_ch     input      valid / ready    positions, radii, masks, skip flags
//   out_ch    output     valid / ready    hit, normal x / y / z in Q1.14
//   APB       input      psel / penable   tolerance_scale at byte address 0
//
// One pair enters per cycle unless stalled. On its way to its result a pair
// passes 5 overlap-test stages, 32 square root stages, 17 divider stages and
// the output register. All stages advance together; while the output register
// holds a result that is not taken, the whole pipeline and in_ch.ready stall.
// Reset is synchronous, clears the valid bits and loads the tolerance register with TOL_RESET.
// ----------------------------------------------------------------------------
module sphere_pair_collision_test import spc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  spc_in_if.sink            in_ch,
  spc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic             adv;
  logic [TOL_W-1:0] tol_r;
  spc_item_t        item;
  logic             geom_valid;
  spc_geom_t        geom;
  logic             root_valid;
  spc_sqrt_t        root_st;
  logic             quo_valid;
  spc_div_t         quo_st;

  logic                          out_valid_r;
  logic                          out_hit_r, out_hit_nxt;
  logic [2:0][NRM_W-1:0]         out_nrm_r, out_nrm_nxt;

  // Register access: one register, byte offset bits are ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && (paddr[CFG_AW-1] == REG_TOLERANCE)) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[CFG_AW-1])
      REG_TOLERANCE: prdata = CFG_DW'(tol_r);
      default:       prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is free or drained.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    item.one_x      = in_ch.one_x;
    item.one_y      = in_ch.one_y;
    item.one_z      = in_ch.one_z;
    item.two_x      = in_ch.two_x;
    item.two_y      = in_ch.two_y;
    item.two_z      = in_ch.two_z;
    item.one_radius = in_ch.one_radius;
    item.two_radius = in_ch.two_radius;
    item.one_masks  = in_ch.one_masks;
    item.two_masks  = in_ch.two_masks;
    item.skip_flags = in_ch.skip_flags;
  end

  spc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_ch.valid),
    .item       (item),
    .tol        (tol_r),
    .geom_valid (geom_valid),
    .geom       (geom)
  );

  spc_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .geom_valid (geom_valid),
    .geom       (geom),
    .root_valid (root_valid),
    .root_st    (root_st)
  );

  spc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .root_valid (root_valid),
    .root_st    (root_st),
    .quo_valid  (quo_valid),
    .quo_st     (quo_st)
  );

  // Clamp, apply the sign and zero the normal for misses and coincident bodies.
  always_comb begin
    logic [Q_W-1:0] q;
    out_hit_nxt = quo_st.hit;
    for (int i = 0; i < 3; i++) begin
      q = (quo_st.quo[i] > NRM_MAX) ? NRM_MAX : quo_st.quo[i];
      if (!quo_st.hit || quo_st.zero) begin
        out_nrm_nxt[i] = '0;
      end else if (quo_st.pos[i]) begin
        out_nrm_nxt[i] = NRM_W'(q);
      end else begin
        out_nrm_nxt[i] = NRM_W'(-q);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= out_hit_nxt;
      out_nrm_r <= out_nrm_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit      = out_hit_r;
  assign out_ch.normal_x = out_nrm_r[0];
  assign out_ch.normal_y = out_nrm_r[1];
  assign out_ch.normal_z = out_nrm_r[2];

  // A miss always carries a zero normal.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |->
      out_ch.normal_x == '0 && out_ch.normal_y == '0 && out_ch.normal_z == '0)
    else $error("miss with nonzero normal");

  // Normal components stay within the unit range.
  a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      out_ch.normal_x <= 16'sd16384 && out_ch.normal_x >= -16'sd16384 &&
      out_ch.normal_y <= 16'sd16384 && out_ch.normal_y >= -16'sd16384 &&
      out_ch.normal_z <= 16'sd16384 && out_ch.normal_z >= -16'sd16384)
    else $error("normal component out of range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result presented right after reset");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sphere pair collision test
// Streams candidate pairs through the block with random idling on both
// channels, predicts each hit and normal in integer arithmetic, and compares
// every result transaction with the oldest prediction. The tolerance register
// is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import spc_pkg::*;

  typedef struct packed {
    logic                    hit;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } collision_t;

  localparam int LATENCY = 55;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  spc_in_if  in_ch ();
  spc_out_if out_ch ();

  sphere_pair_collision_test u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  spc_item_t  pending_pairs[$];
  collision_t expected_hits[$];
  logic [TOL_W-1:0] tol_scale = TOL_RESET;
  int  mismatches = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;

  // Integer square root, bit by bit.
  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One normal component: rounded quotient, clamped to one in Q1.14.
  function automatic logic signed [NRM_W-1:0] unit_axis(longint v, logic [63:0] s);
    logic [63:0] m;
    logic [63:0] q;
    m = (v < 0) ? -v : v;
    if (s == 0) return '0;
    q = ((m << 28) + (s >> 1)) / s;
    if (q > 16384) q = 16384;
    return (v < 0) ? -q[15:0] : q[15:0];
  endfunction

  // Filtering, overlap test and unit normal of one pair.
  function automatic collision_t collide(spc_item_t p);
    collision_t  c;
    longint      d[3];
    logic [63:0] a;
    logic [63:0] rsum;
    logic [63:0] dist2;
    logic [63:0] s;
    c = '0;
    rsum = p.one_radius + p.two_radius;
    if ((p.one_masks[31:16] & p.two_masks[15:0]) == 0) return c;
    if ((p.two_masks[31:16] & p.one_masks[15:0]) == 0) return c;
    if (p.skip_flags != 0) return c;
    d[0] = longint'(p.one_x) - longint'(p.two_x);
    d[1] = longint'(p.one_y) - longint'(p.two_y);
    d[2] = longint'(p.one_z) - longint'(p.two_z);
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      a = (d[i] < 0) ? -d[i] : d[i];
      if (a > rsum) return c;
      dist2 += a * a;
    end
    if ((dist2 << 8) > rsum * rsum * tol_scale) return c;
    s = root64(dist2 << 28);
    c.hit = 1'b1;
    c.nx = unit_axis(-d[0], s);
    c.ny = unit_axis(-d[1], s);
    c.nz = unit_axis(-d[2], s);
    return c;
  endfunction

  task automatic report(string what, collision_t got, collision_t want);
    mismatches++;
    $display("mismatch %s at result %0d: got %0b %0d %0d %0d, want %0b %0d %0d %0d",
             what, results_seen, got.hit, got.nx, got.ny, got.nz,
             want.hit, want.nx, want.ny, want.nz);
  endtask

  // Driver: presents queued pairs, with random idle bursts.
  // The presented pair stays at the head of the queue until it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_hits.push_back(collide(pending_pairs.pop_front()));
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 7);
        in_ch.valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.one_x, in_ch.one_y, in_ch.one_z, in_ch.two_x, in_ch.two_y,
         in_ch.two_z, in_ch.one_radius, in_ch.two_radius, in_ch.one_masks,
         in_ch.two_masks, in_ch.skip_flags} <= pending_pairs[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: takes results with random stalls and checks them.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        collision_t got;
        collision_t want;
        got = {out_ch.hit, out_ch.normal_x, out_ch.normal_y, out_ch.normal_z};
        results_seen++;
        if (got.hit) hits_seen++;
        if (expected_hits.size() == 0) begin
          report("unexpected", got, '0);
        end else begin
          want = expected_hits.pop_front();
          if (got.hit != want.hit) report("hit", got, want);
          if (got.nx != want.nx) report("normal_x", got, want);
          if (got.ny != want.ny) report("normal_y", got, want);
          if (got.nz != want.nz) report("normal_z", got, want);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL sphere_pair_collision_test");
      $finish;
    end
  end

  // Random pair; most are built near each other so that they can collide.
  function automatic spc_item_t random_pair();
    spc_item_t p;
    int        sel;
    p = '0;
    sel = $urandom_range(0, 9);
    p.one_x = POS_W'($urandom); p.one_y = POS_W'($urandom); p.one_z = POS_W'($urandom);
    p.one_radius = (sel < 4) ? RAD_W'($urandom_range(0, 4095)) : RAD_W'($urandom);
    p.two_radius = (sel < 4) ? RAD_W'($urandom_range(0, 4095)) : RAD_W'($urandom);
    if (sel < 8) begin
      logic [17:0] span;
      span = {2'b00, p.one_radius} + {2'b00, p.two_radius} + 18'd1;
      p.two_x = POS_W'(p.one_x + $signed($urandom_range(0, 2 * span)) - $signed(span));
      p.two_y = POS_W'(p.one_y + $signed($urandom_range(0, 2 * span)) - $signed(span));
      p.two_z = POS_W'(p.one_z + $signed($urandom_range(0, 2 * span)) - $signed(span));
    end else begin
      p.two_x = POS_W'($urandom); p.two_y = POS_W'($urandom); p.two_z = POS_W'($urandom);
    end
    if ($urandom_range(0, 4) != 0) begin
      p.one_masks = {16'hFFFF, 16'($urandom)} | 32'h1;
      p.two_masks = {16'($urandom) | 16'h1, 16'($urandom)} | 32'h1;
      p.one_masks[31:16] = 16'($urandom) | 16'h1;
    end else begin
      p.one_masks = $urandom;
      p.two_masks = $urandom;
    end
    p.skip_flags = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
    return p;
  endfunction

  // Pair with explicit geometry and matching masks.
  function automatic spc_item_t plain_pair(int ax, int ay, int az, int bx, int by,
                                           int bz, int ra, int rb);
    spc_item_t p;
    p = '0;
    p.one_x = POS_W'(ax); p.one_y = POS_W'(ay); p.one_z = POS_W'(az);
    p.two_x = POS_W'(bx); p.two_y = POS_W'(by); p.two_z = POS_W'(bz);
    p.one_radius = RAD_W'(ra); p.two_radius = RAD_W'(rb);
    p.one_masks = 32'hFFFF_FFFF;
    p.two_masks = 32'hFFFF_FFFF;
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_ch.valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_TOLERANCE, 2'b00}; pwdata <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tol_scale = value;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) pending_pairs.push_back(random_pair());
  endtask

  initial begin
    spc_item_t p;
    logic [TOL_W-1:0] settings[5];
    settings = '{10'd256, 10'd512, 10'd0, 10'd1023, 10'd300};
    in_ch.valid = 1'b0;
    {in_ch.one_x, in_ch.one_y, in_ch.one_z, in_ch.two_x, in_ch.two_y, in_ch.two_z,
     in_ch.one_radius, in_ch.two_radius, in_ch.one_masks, in_ch.two_masks,
     in_ch.skip_flags} = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs: coincident, touching, axis reject, extremes, filters.
    pending_pairs.push_back(plain_pair(0, 0, 0, 0, 0, 0, 256, 256));
    pending_pairs.push_back(plain_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(plain_pair(0, 0, 0, 100, 0, 0, 0, 0));
    pending_pairs.push_back(plain_pair(0, 0, 0, 512, 0, 0, 256, 256));
    pending_pairs.push_back(plain_pair(0, 0, 0, 513, 0, 0, 256, 256));
    pending_pairs.push_back(plain_pair(0, 0, 0, -300, 300, -300, 256, 256));
    pending_pairs.push_back(plain_pair(-8388608, -8388608, -8388608,
                                       -8388608 + 65535, -8388608, -8388608 + 9,
                                       65535, 65535));
    pending_pairs.push_back(plain_pair(8388607, 8388607, 8388607,
                                       8388607 - 65535, 8388607 - 1, 8388607,
                                       65535, 65535));
    pending_pairs.push_back(plain_pair(-8388608, 0, 0, 8388607, 0, 0, 65535, 65535));
    pending_pairs.push_back(plain_pair(1, 1, 1, -1, -1, -1, 1, 1));
    pending_pairs.push_back(plain_pair(0, 0, 0, 90000, 90000, 90000, 65535, 65535));
    for (int f = 1; f < 4; f++) begin
      p = plain_pair(0, 0, 0, 10, 10, 10, 100, 100);
      p.skip_flags = FLAG_W'(f);
      pending_pairs.push_back(p);
    end
    p = plain_pair(0, 0, 0, 10, 0, 0, 100, 100);
    p.one_masks = 32'h0001_0002;
    p.two_masks = 32'h0002_0001;
    pending_pairs.push_back(p);
    p.two_masks = 32'h0002_0004;
    pending_pairs.push_back(p);
    p.two_masks = 32'h0004_0001;
    pending_pairs.push_back(p);
    p.one_masks = 32'h8000_8000;
    p.two_masks = 32'h8000_8000;
    pending_pairs.push_back(p);
    random_phase(300);

    // Hold the sender until every result is back.
    wait_drained();

    for (int k = 0; k < 5; k++) begin
      write_tolerance(settings[k]);
      random_phase(200);
      wait_drained();
    end
    write_tolerance(TOL_RESET);
    quiet = 1'b1;
    random_phase(150);
    wait_drained();

    $display("checked %0d results, %0d hits, over six tolerance settings",
             results_seen, hits_seen);
    if (mismatches == 0) begin
      $display("PASS sphere_pair_collision_test");
    end else begin
      $display("FAIL sphere_pair_collision_test");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/spc_pkg.sv
hdl/spc_if.sv
hdl/spc_front.sv
hdl/spc_sqrt.sv
hdl/spc_div.sv
hdl/sphere_pair_collision_test.sv
tb/sv/tb_top.sv
